// ===== src/text_console_writer_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the text console writer
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// Same-cycle implication, masked during reset
`define TCW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("text console writer: assertion failed");

// Next-cycle implication, masked during reset
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("text console writer: assertion failed");

`endif

// ===== src/tcw_pkg.sv =====
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types of the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

   // field widths of the channel payloads
   localparam int ACTION_W   = 2;
   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int ROW_FIELD_W = 5;
   localparam int COL_FIELD_W = 7;

   // item actions; the fourth code does nothing
   typedef enum logic [ACTION_W-1:0] {
      ACT_PUT   = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   // special characters and reset attribute
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

   localparam int CELL_W = CHAR_W + ATTR_W;

endpackage

// ===== src/tcw_if.sv =====
// ---------------------------------------------------------------------------
// tcw_if
// Valid/ready channels of the text console writer: request, response, CSR.
// ---------------------------------------------------------------------------
interface tcw_req_if;
   import tcw_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [ACTION_W-1:0]    action;
   logic [CHAR_W-1:0]      char_code;
   logic [ROW_FIELD_W-1:0] read_row;
   logic [COL_FIELD_W-1:0] read_col;

   modport source (output valid, action, char_code, read_row, read_col, input ready);
   modport sink   (input valid, action, char_code, read_row, read_col, output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [ROW_FIELD_W-1:0] cursor_row;
   logic [COL_FIELD_W-1:0] cursor_col;
   logic [CHAR_W-1:0]      cell_char;
   logic [ATTR_W-1:0]      cell_attr;

   modport source (output valid, cursor_row, cursor_col, cell_char, cell_attr,
                   input ready);
   modport sink   (input valid, cursor_row, cursor_col, cell_char, cell_attr,
                   output ready);
endinterface

interface tcw_csr_if;
   import tcw_pkg::*;
   logic              valid;
   logic              ready;
   logic [ATTR_W-1:0] text_attribute;

   modport source (output valid, text_attribute, input ready);
   modport sink   (input valid, text_attribute, output ready);
endinterface

// ===== src/tcw_ram.sv =====
// ---------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/text_console_writer_top.sv =====
// ---------------------------------------------------------------------------
// text_console_writer_top
// Character-cell text terminal: cell RAM, cursor, scroll and clear sequencer.
// ---------------------------------------------------------------------------
//  channel  | direction | carries
//  req_ch   | in        | action, char_code, read_row, read_col
//  rsp_ch   | out       | cursor_row, cursor_col, cell_char, cell_attr
//  csr_ch   | in        | text_attribute (always ready)
//
//  Put without scroll, unused action, read off screen: ST_DONE loads the
//  result register. Read on screen: ST_READ first latches the registered RAM
//  read data. Scroll: ST_FILL blanks only the bottom row; rows rotate through
//  a top-row pointer. Clear: ST_FILL writes all ROWS*COLS cells, one cell per
//  cycle on the RAM write port. After reset a clearing pass precedes any item.
//  A stalled result waits in the result register and the next item is taken;
//  that item then holds in ST_DONE, with req_ch not ready, until it drains.
// ---------------------------------------------------------------------------
`include "text_console_writer_top_assert.svh"

module text_console_writer_top #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  logic      clock,
   input  logic      reset,
   tcw_req_if.sink   req_ch,
   tcw_rsp_if.source rsp_ch,
   tcw_csr_if.sink   csr_ch
);
   import tcw_pkg::*;

   localparam int CELLS = ROWS * COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int NW    = $clog2(CELLS + 1);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLS);
   localparam logic [RW:0]   ROWS_W  = (RW + 1)'(ROWS);
   localparam logic [CW:0]   COLS_W  = (CW + 1)'(COLS);
   localparam logic [NW-1:0] CELLS_N = NW'(CELLS);
   localparam logic [NW-1:0] COLS_N  = NW'(COLS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_FILL,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [RW-1:0]          cur_row_ff, cur_row_in;
   logic [CW-1:0]          cur_col_ff, cur_col_in;
   logic [RW-1:0]          top_ff, top_in;
   logic [AW-1:0]          fill_addr_ff, fill_addr_in;
   logic [NW-1:0]          fill_cnt_ff, fill_cnt_in;
   logic [ATTR_W-1:0]      fill_attr_ff, fill_attr_in;
   logic                   fill_rsp_ff, fill_rsp_in;
   logic [ATTR_W-1:0]      attr_ff, attr_in;
   logic [CHAR_W-1:0]      cell_char_ff, cell_char_in;
   logic [ATTR_W-1:0]      cell_attr_ff, cell_attr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ROW_FIELD_W-1:0] rsp_row_ff, rsp_row_in;
   logic [COL_FIELD_W-1:0] rsp_col_ff, rsp_col_in;
   logic [CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]      rsp_attr_ff, rsp_attr_in;

   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [CELL_W-1:0]      ram_wdata;
   logic [AW-1:0]          ram_raddr;
   logic [CELL_W-1:0]      ram_rdata;

   logic                   req_fire;
   logic [RW:0]            next_row;
   logic [CW:0]            next_col;
   logic [RW:0]            top_inc;
   logic [RW-1:0]          rd_row;
   logic [CW-1:0]          rd_col;

   // logical (row, col) to RAM address through the rotating top row
   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                               input logic [CW-1:0] col,
                                               input logic [RW-1:0] top);
      logic [RW:0]   sum;
      logic [RW-1:0] phys;
      sum = {1'b0, row} + {1'b0, top};
      if (sum >= ROWS_W) begin
         sum = sum - ROWS_W;
      end
      phys = sum[RW-1:0];
      return AW'(phys) * AW'(COLS) + AW'(col);
   endfunction

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign rd_row    = RW'(req_ch.read_row);
   assign rd_col    = CW'(req_ch.read_col);
   assign ram_raddr = cell_addr(rd_row, rd_col, top_ff);

   // sequencer: put, read, clear, scroll, result hand-off
   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      top_in       = top_ff;
      fill_addr_in = fill_addr_ff;
      fill_cnt_in  = fill_cnt_ff;
      fill_attr_in = fill_attr_ff;
      fill_rsp_in  = fill_rsp_ff;
      cell_char_in = cell_char_ff;
      cell_attr_in = cell_attr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      ram_we       = 1'b0;
      ram_waddr    = cell_addr(cur_row_ff, cur_col_ff, top_ff);
      ram_wdata    = {attr_ff, req_ch.char_code};
      next_row     = {1'b0, cur_row_ff};
      next_col     = {1'b0, cur_col_ff};
      top_inc      = {1'b0, top_ff} + (RW + 1)'(1);

      // result register drains independently
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cell_char_in = '0;
               cell_attr_in = '0;
               state_in     = ST_DONE;
               unique case (req_ch.action)
                  ACT_PUT: begin
                     priority if (req_ch.char_code == CH_NEWLINE) begin
                        next_col = '0;
                        next_row = {1'b0, cur_row_ff} + (RW + 1)'(1);
                     end else if (req_ch.char_code == CH_BACKSPACE) begin
                        if (cur_col_ff != '0) begin
                           next_col = {1'b0, cur_col_ff - CW'(1)};
                        end else if (cur_row_ff != '0) begin
                           next_row = {1'b0, cur_row_ff - RW'(1)};
                           next_col = {1'b0, CW'(COLS - 1)};
                        end
                        ram_we    = 1'b1;
                        ram_waddr = cell_addr(next_row[RW-1:0], next_col[CW-1:0], top_ff);
                        ram_wdata = {attr_ff, CH_SPACE};
                     end else begin
                        ram_we   = 1'b1;
                        next_col = {1'b0, cur_col_ff} + (CW + 1)'(1);
                        if (next_col == COLS_W) begin
                           next_col = '0;
                           next_row = {1'b0, cur_row_ff} + (RW + 1)'(1);
                        end
                     end
                     cur_col_in = next_col[CW-1:0];
                     if (next_row == ROWS_W) begin
                        // scroll: old top row becomes the blank bottom row
                        cur_row_in   = RW'(ROWS - 1);
                        fill_addr_in = AW'(top_ff) * AW'(COLS);
                        fill_cnt_in  = COLS_N;
                        fill_attr_in = attr_ff;
                        fill_rsp_in  = 1'b1;
                        top_in       = (top_inc == ROWS_W) ? '0 : top_inc[RW-1:0];
                        state_in     = ST_FILL;
                     end else begin
                        cur_row_in = next_row[RW-1:0];
                     end
                  end
                  ACT_READ: begin
                     if (int'(req_ch.read_row) < ROWS && int'(req_ch.read_col) < COLS) begin
                        state_in = ST_READ;
                     end
                  end
                  ACT_CLEAR: begin
                     cur_row_in   = '0;
                     cur_col_in   = '0;
                     top_in       = '0;
                     fill_addr_in = '0;
                     fill_cnt_in  = CELLS_N;
                     fill_attr_in = attr_ff;
                     fill_rsp_in  = 1'b1;
                     state_in     = ST_FILL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            cell_char_in = ram_rdata[CHAR_W-1:0];
            cell_attr_in = ram_rdata[CELL_W-1:CHAR_W];
            state_in     = ST_DONE;
         end
         ST_FILL: begin
            ram_we       = 1'b1;
            ram_waddr    = fill_addr_ff;
            ram_wdata    = {fill_attr_ff, CH_SPACE};
            fill_addr_in = fill_addr_ff + AW'(1);
            fill_cnt_in  = fill_cnt_ff - NW'(1);
            if (fill_cnt_ff == NW'(1)) begin
               state_in = fill_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = ROW_FIELD_W'(cur_row_ff);
               rsp_col_in   = COL_FIELD_W'(cur_col_ff);
               rsp_char_in  = cell_char_ff;
               rsp_attr_in  = cell_attr_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration register
   assign attr_in = csr_ch.valid ? csr_ch.text_attribute : attr_ff;

   // state and registered outputs; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         top_ff       <= '0;
         fill_addr_ff <= '0;
         fill_cnt_ff  <= CELLS_N;
         fill_attr_ff <= RESET_ATTR;
         fill_rsp_ff  <= 1'b0;
         attr_ff      <= RESET_ATTR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         top_ff       <= top_in;
         fill_addr_ff <= fill_addr_in;
         fill_cnt_ff  <= fill_cnt_in;
         fill_attr_ff <= fill_attr_in;
         fill_rsp_ff  <= fill_rsp_in;
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cell_char_ff <= cell_char_in;
      cell_attr_ff <= cell_attr_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_attr_ff  <= rsp_attr_in;
   end

   // cell store
   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ports
   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign csr_ch.ready      = 1'b1;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.cursor_row = rsp_row_ff;
   assign rsp_ch.cursor_col = rsp_col_ff;
   assign rsp_ch.cell_char  = rsp_char_ff;
   assign rsp_ch.cell_attr  = rsp_attr_ff;

   // checks
   `TCW_ASSERT_IMP(a_cursor_on_screen, clock, reset, 1'b1,
      int'(cur_row_ff) < ROWS && int'(cur_col_ff) < COLS && int'(top_ff) < ROWS)
   `TCW_ASSERT_IMP(a_fill_in_range, clock, reset, state_ff == ST_FILL,
      fill_cnt_ff != '0 && (int'(fill_addr_ff) + int'(fill_cnt_ff)) <= CELLS)
   `TCW_ASSERT_NEXT(a_result_loaded, clock, reset,
      state_ff == ST_DONE && (!rsp_valid_ff || rsp_ch.ready),
      rsp_valid_ff && state_ff == ST_IDLE)

endmodule
